[hw/rtl/branch_unit_with_return_stack_macros.svh]
// Assertion macros shared by the branch unit RTL
`ifndef BRANCH_UNIT_WITH_RETURN_STACK_MACROS_SVH
`define BRANCH_UNIT_WITH_RETURN_STACK_MACROS_SVH

// Check a consequence in the same cycle, outside reset
`define BRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("branch unit check failed");

// Check a consequence in the next cycle, outside reset
`define BRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("branch unit check failed");

// Check a consequence that must also hold across reset
`define BRS_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("branch unit reset check failed");

`endif

[hw/rtl/brs_pkg.sv]
// Shared types and codes of the branch unit with return stack
`timescale 1ns / 1ps
`default_nettype none
package brs_pkg;

  localparam int LINE_W  = 15;
  localparam int DEPTH_W = 9;

  typedef enum logic [3:0] {
    OP_EMPTY   = 4'd0,
    OP_EVAL    = 4'd1,
    OP_BREAK   = 4'd2,
    OP_RET     = 4'd3,
    OP_JMP     = 4'd4,
    OP_JZ      = 4'd5,
    OP_JNZ     = 4'd6,
    OP_CALL    = 4'd7,
    OP_CALLZ   = 4'd8,
    OP_CALLNZ  = 4'd9,
    OP_RESTART = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_RETMAIN  = 3'd1,
    ST_PASTEND  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_INT     = 2'd0,
    KIND_FLOAT   = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  // One result beat
  typedef struct packed {
    logic [LINE_W-1:0]  next_line;
    status_t            status;
    logic [DEPTH_W-1:0] stack_depth;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/brs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module brs_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/brs_core.sv]
// Line pointer, zero flag, status and top-of-stack control over the stack RAM
`timescale 1ns / 1ps
`default_nettype none
module brs_core #(
  parameter int STACK_DEPTH = 256,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [14:0]           cfg_wr_data,
  input  wire logic                  accept,
  input  wire logic [3:0]            operation,
  input  wire logic [14:0]           target_line,
  input  wire logic [1:0]            value_kind,
  input  wire logic [63:0]           int_value,
  input  wire logic [63:0]           real_bits,
  input  wire logic [63:0]           imag_bits,
  output brs_pkg::res_t              result,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [14:0]                ram_wdata,
  output logic [AW-1:0]              ram_raddr,
  input  wire logic [14:0]           ram_rdata
);
  import brs_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [LINE_W-1:0] line_count_r;
  logic [LINE_W-1:0] lp_r, lp_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic              zero_r, zero_nxt;
  status_t           st_r, st_nxt;
  logic [LINE_W-1:0] tos_r, tos_nxt;
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [LINE_W-1:0] fwd_data_r;

  logic [LINE_W-1:0] lp_inc;
  logic [LINE_W-1:0] below;
  logic              is_zero;
  logic              push, pop;
  logic              stack_full;
  logic [SPW-1:0]    sp_eff, rd_sp, wr_sp;
  logic [SPW+8:0]    depth_ext;
  op_t               op;

  assign op         = op_t'(operation);
  assign lp_inc     = lp_r + LINE_W'(1);
  assign stack_full = (sp_r >= SPW'(STACK_DEPTH));
  // Entry just under the top of stack, with the last write forwarded
  assign below      = fwd_valid_r ? fwd_data_r : ram_rdata;

  // Zero test of the evaluated result
  always_comb begin
    case (kind_t'(value_kind))
      KIND_INT:     is_zero = (int_value == 64'd0);
      KIND_FLOAT:   is_zero = ((real_bits & MAG_MASK) == 64'd0);
      KIND_COMPLEX: is_zero = ((real_bits & MAG_MASK) == 64'd0) &&
                              ((imag_bits & MAG_MASK) == 64'd0);
      default:      is_zero = 1'b0;
    endcase
  end

  // Next state of the control registers for the current beat
  always_comb begin
    lp_nxt   = lp_r;
    sp_nxt   = sp_r;
    zero_nxt = zero_r;
    st_nxt   = st_r;
    push     = 1'b0;
    pop      = 1'b0;
    if (op == OP_RESTART) begin
      lp_nxt   = '0;
      sp_nxt   = '0;
      zero_nxt = 1'b0;
      st_nxt   = ST_RUN;
    end else if (st_r == ST_RUN) begin
      if (lp_r >= line_count_r) begin
        st_nxt = ST_PASTEND;
      end else begin
        case (op)
          OP_EMPTY, OP_BREAK: begin
            lp_nxt = lp_inc;
          end
          OP_EVAL: begin
            zero_nxt = is_zero;
            lp_nxt   = lp_inc;
          end
          OP_RET: begin
            if (sp_r == '0) begin
              st_nxt = ST_RETMAIN;
            end else begin
              pop = 1'b1;
            end
          end
          OP_JMP: begin
            lp_nxt = target_line;
          end
          OP_JZ: begin
            lp_nxt = zero_r ? target_line : lp_inc;
          end
          OP_JNZ: begin
            lp_nxt = zero_r ? lp_inc : target_line;
          end
          OP_CALL: begin
            push = 1'b1;
          end
          OP_CALLZ: begin
            if (zero_r) begin
              push = 1'b1;
            end else begin
              lp_nxt = lp_inc;
            end
          end
          OP_CALLNZ: begin
            if (!zero_r) begin
              push = 1'b1;
            end else begin
              lp_nxt = lp_inc;
            end
          end
          default: begin
            st_nxt = ST_UNKNOWN;
          end
        endcase
        // Drop a push on a full stack
        if (push && stack_full) begin
          push   = 1'b0;
          st_nxt = ST_OVERFLOW;
        end
        if (push) begin
          sp_nxt = sp_r + SPW'(1);
          lp_nxt = target_line;
        end
        if (pop) begin
          sp_nxt = sp_r - SPW'(1);
          lp_nxt = tos_r + LINE_W'(1);
        end
        if (st_nxt == ST_RUN && lp_nxt >= line_count_r) begin
          st_nxt = ST_PASTEND;
        end
      end
    end
  end

  // Top-of-stack register and RAM accesses
  always_comb begin
    tos_nxt   = tos_r;
    ram_we    = 1'b0;
    wr_sp     = sp_r - SPW'(1);
    ram_waddr = wr_sp[AW-1:0];
    ram_wdata = tos_r;
    if (accept && push) begin
      tos_nxt = lp_r;
      ram_we  = (sp_r != '0);
    end else if (accept && pop) begin
      tos_nxt = below;
    end
    // Read ahead the entry under the top for the depth of the next cycle
    sp_eff        = accept ? sp_nxt : sp_r;
    rd_sp         = sp_eff - SPW'(2);
    ram_raddr     = rd_sp[AW-1:0];
    fwd_valid_nxt = ram_we && (ram_waddr == ram_raddr);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      lp_r         <= '0;
      sp_r         <= '0;
      zero_r       <= 1'b0;
      st_r         <= ST_RUN;
      fwd_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_count_r <= cfg_wr_data;
      end
      if (accept) begin
        lp_r   <= lp_nxt;
        sp_r   <= sp_nxt;
        zero_r <= zero_nxt;
        st_r   <= st_nxt;
      end
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    fwd_data_r <= ram_wdata;
  end

  // Result of the accepted beat
  assign depth_ext          = {9'd0, sp_nxt};
  assign result.next_line   = lp_nxt;
  assign result.status      = st_nxt;
  assign result.stack_depth = depth_ext[DEPTH_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/brs_skid.sv]
// Two-entry output buffer that decouples result stalls from input acceptance
`timescale 1ns / 1ps
`default_nettype none
module brs_skid (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brs_pkg::res_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  wire logic          out_ready,
  output brs_pkg::res_t      out_data
);
  import brs_pkg::*;

  logic out_valid_r, sk_valid_r;
  res_t out_data_r, sk_data_r;

  assign can_push  = !sk_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Valid flags: advance on drain, hold a beat in the skid on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      sk_valid_r <= 1'b1;
    end
  end

  // Payloads
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_data_r <= sk_valid_r ? sk_data_r : push_data;
    end else if (push) begin
      sk_data_r <= push_data;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/branch_unit_with_return_stack.sv]
// A result beat is registered into the output buffer when its input is accepted.
// Throughput: one line per cycle while in_ready is high; a top-of-stack
//   register plus read-ahead of the entry beneath it hides the stack RAM read.
// A two-entry output buffer keeps input accepting while one result is stalled.
// Reset (synchronous, rst_n low): clears pointer, depth, zero flag, status and
//   line_count; the stack RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module branch_unit_with_return_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [14:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_operation,
  input  wire logic [14:0] in_target_line,
  input  wire logic [1:0]  in_value_kind,
  input  wire logic [63:0] in_int_value,
  input  wire logic [63:0] in_real_bits,
  input  wire logic [63:0] in_imag_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      out_next_line,
  output logic [2:0]       out_status,
  output logic [8:0]       out_stack_depth
);
  import brs_pkg::*;
`include "branch_unit_with_return_stack_macros.svh"

  localparam int AW = $clog2(STACK_DEPTH);

  logic          accept;
  res_t          core_res, out_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [14:0]   ram_wdata, ram_rdata;

  assign accept = in_valid && in_ready;

  brs_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .operation   (in_operation),
    .target_line (in_target_line),
    .value_kind  (in_value_kind),
    .int_value   (in_int_value),
    .real_bits   (in_real_bits),
    .imag_bits   (in_imag_bits),
    .result      (core_res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  brs_ram #(
    .WIDTH (15),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brs_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_next_line   = out_res.next_line;
  assign out_status      = out_res.status;
  assign out_stack_depth = out_res.stack_depth;

  // A full output buffer always shows a result
  `BRS_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid)
  // A beat accepted into an empty buffer appears on the next cycle
  `BRS_ASSERT_NEXT(a_beat_latency, accept && !out_valid, out_valid)
  // No result on the first cycle out of reset
  `BRS_ASSERT_ALWAYS(a_reset_empty, rst_n && $past(!rst_n), !out_valid && in_ready)

endmodule
`default_nettype wire
